// ===== sv/gpc_pkg.sv =====
`default_nettype none
package gpc_pkg;
	localparam int PARTICLES = 64;
	localparam int PW = 6;
	localparam int FRAC_BITS = 16;
	localparam int COEF_FRAC = 24;
	localparam int JERK_FRAC = 8;
	localparam int NREG = 8;
	localparam int MEM_AW = PW + 5;

	typedef enum logic [1:0] {
		ACT_PREDICT = 2'd0,
		ACT_CORRECT = 2'd1,
		ACT_LOAD    = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_STEP  = 3'd0,
		REG_HSQ   = 3'd1,
		REG_SCUBE = 3'd2,
		REG_CPOS  = 3'd3,
		REG_CVEL  = 3'd4,
		REG_CJERK = 3'd5,
		REG_IMASS = 3'd6,
		REG_IINER = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_READ,
		ST_CALC,
		ST_WRITE,
		ST_OUT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
		if (x > 48'sh7fffffff) return 32'sh7fffffff;
		if (x < -48'sh80000000) return -32'sh80000000;
		return x[31:0];
	endfunction
endpackage
`default_nettype wire

// ===== sv/gear_predictor_corrector.sv =====
// Fourth-order Gear predictor-corrector over 64 particles. After reset a clearing pass over
// all 2048 words zeroes the state memory; busy is high and start is refused meanwhile. An item
// reads its 24 words through the single memory port, runs its products on the one
// multiplier (36 for predict, 24 for correct, none for load or the unused action), writes
// the 24 words back, and shows the result; a new start is taken only once the block is idle
// again. The result is shown for one cycle on done and cannot be stalled; registers are
// written only while the block is idle.
`default_nettype none
module gear_predictor_corrector import gpc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         action,
	input  wire logic [5:0]         particle,
	input  wire logic [2:0]         slot,
	input  wire logic signed [31:0] vec_x, vec_y, vec_z,
	input  wire logic signed [31:0] torque_x, torque_y, torque_z,
	input  wire logic signed [31:0] gravity_x, gravity_y, gravity_z,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	output logic                    done,
	output logic [5:0]              which_particle,
	output logic signed [31:0]      pos_x, pos_y, pos_z,
	output logic signed [31:0]      vel_x, vel_y, vel_z,
	output logic signed [31:0]      spin_x, spin_y, spin_z
);
	state_t state_q, state_d;
	logic [31:0] regs_q [NREG];
	logic signed [31:0] mem [2**MEM_AW];
	logic signed [31:0] rd_q;
	logic signed [31:0] d_q [24];
	logic signed [31:0] accel_q [2][3];
	logic signed [47:0] sum_q;
	logic [MEM_AW-1:0] clr_q;
	logic [4:0] cnt_q;
	logic ph_q;
	logic set_q;
	logic pre_q;
	logic [1:0] ax_q;
	logic [2:0] tm_q;
	action_t act_q;
	logic [2:0] slot_q;
	logic [5:0] part_q;
	logic signed [31:0] vin_q [3], tq_q [3], gr_q [3];
	logic signed [31:0] pa;
	logic [31:0] pc;
	logic [4:0] ps;
	logic signed [47:0] prod_s1;
	logic [4:0] base, i0, i1, i2, i3, dst;
	logic first, fin, last_tm, last_op;
	logic signed [47:0] sum;
	logic [MEM_AW-1:0] addr;

	assign cfg_ready = (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREG; i++) regs_q[i] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	// operand select for the current product
	always_comb begin
		base = set_q ? 5'd12 : 5'd0;
		i0 = base + 5'(ax_q);
		i1 = base + 5'd3 + 5'(ax_q);
		i2 = base + 5'd6 + 5'(ax_q);
		i3 = base + 5'd9 + 5'(ax_q);
		pa = '0;
		pc = '0;
		ps = 5'(COEF_FRAC);
		dst = i0;
		first = 1'b1;
		fin = 1'b1;
		last_tm = 1'b1;
		case (act_q)
			ACT_PREDICT: begin
				last_tm = (tm_q == 3'd5);
				case (tm_q)
					3'd0: begin
						pa = d_q[i1]; pc = regs_q[REG_STEP]; fin = 1'b0;
					end
					3'd1: begin
						pa = d_q[i2]; pc = regs_q[REG_HSQ]; first = 1'b0; fin = 1'b0;
					end
					3'd2: begin
						pa = d_q[i3]; pc = regs_q[REG_SCUBE]; first = 1'b0;
					end
					3'd3: begin
						pa = d_q[i2]; pc = regs_q[REG_STEP]; dst = i1; fin = 1'b0;
					end
					3'd4: begin
						pa = d_q[i3]; pc = regs_q[REG_HSQ]; dst = i1; first = 1'b0;
					end
					default: begin
						pa = d_q[i3]; pc = regs_q[REG_STEP]; dst = i2;
					end
				endcase
			end
			ACT_CORRECT: begin
				if (pre_q) begin
					pa = set_q ? tq_q[ax_q] : vin_q[ax_q];
					pc = set_q ? regs_q[REG_IINER] : regs_q[REG_IMASS];
					ps = 5'(FRAC_BITS);
				end else begin
					last_tm = (tm_q == 3'd2);
					pa = sat32(48'(accel_q[set_q][ax_q]) - 48'(d_q[i2]));
					case (tm_q)
						3'd0: begin pc = regs_q[REG_CPOS]; dst = i0; end
						3'd1: begin pc = regs_q[REG_CVEL]; dst = i1; end
						default: begin pc = regs_q[REG_CJERK]; ps = 5'(JERK_FRAC); dst = i3; end
					endcase
				end
			end
			default: ;
		endcase
		sum = (first ? 48'(d_q[dst]) : sum_q) + prod_s1;
		last_op = last_tm && (ax_q == 2'd2) && set_q && !pre_q;
	end

	gpc_mac u_mac (.clk(clk), .a(pa), .c(pc), .shift(ps), .prod_s1(prod_s1));

	assign addr = {part_q, cnt_q};

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) mem[clr_q] <= '0;
		else if (state_q == ST_WRITE) mem[addr] <= d_q[cnt_q];
		rd_q <= mem[addr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (&clr_q) state_d = ST_IDLE;
			ST_IDLE: if (start) state_d = ST_READ;
			ST_READ: if (cnt_q == 5'd24) state_d = ST_CALC;
			ST_CALC: begin
				if (act_q != ACT_PREDICT && act_q != ACT_CORRECT) state_d = ST_WRITE;
				else if (ph_q && last_op) state_d = ST_WRITE;
			end
			ST_WRITE: if (cnt_q == 5'd23) state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
			ph_q <= 1'b0;
			set_q <= 1'b0;
			pre_q <= 1'b0;
			ax_q <= '0;
			tm_q <= '0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					cnt_q <= '0;
					ph_q <= 1'b0;
					set_q <= 1'b0;
					ax_q <= '0;
					tm_q <= '0;
					pre_q <= (action == ACT_CORRECT);
				end
				ST_READ: cnt_q <= (cnt_q == 5'd24) ? 5'd0 : cnt_q + 1'b1;
				ST_CALC: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (!last_tm) tm_q <= tm_q + 3'd1;
						else begin
							tm_q <= '0;
							if (ax_q != 2'd2) ax_q <= ax_q + 2'd1;
							else begin
								ax_q <= '0;
								set_q <= ~set_q;
								if (set_q) pre_q <= 1'b0;
							end
						end
					end
				end
				ST_WRITE: cnt_q <= cnt_q + 1'b1;
				ST_OUT: done <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				act_q <= action_t'(action);
				slot_q <= slot;
				part_q <= particle;
				vin_q[0] <= vec_x; vin_q[1] <= vec_y; vin_q[2] <= vec_z;
				tq_q[0] <= torque_x; tq_q[1] <= torque_y; tq_q[2] <= torque_z;
				gr_q[0] <= gravity_x; gr_q[1] <= gravity_y; gr_q[2] <= gravity_z;
			end
			ST_READ: if (cnt_q != 5'd0) d_q[cnt_q - 5'd1] <= rd_q;
			ST_CALC: begin
				if (act_q == ACT_LOAD)
					for (int a = 0; a < 3; a++)
						d_q[(slot_q[2] ? 5'd12 : 5'd0) + 5'(slot_q[1:0]) * 5'd3 + 5'(a)]
							<= vin_q[a];
				if (ph_q) begin
					if (act_q == ACT_PREDICT) begin
						sum_q <= sum;
						if (fin) d_q[dst] <= sat32(sum);
					end else if (act_q == ACT_CORRECT) begin
						if (pre_q)
							accel_q[set_q][ax_q] <= sat32(set_q ? prod_s1
								: prod_s1 + 48'(gr_q[ax_q]));
						else begin
							d_q[dst] <= sat32(sum);
							if (tm_q == 3'd2) d_q[i2] <= accel_q[set_q][ax_q];
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE && cnt_q == 5'd23) begin
			which_particle <= part_q;
			pos_x <= d_q[0]; pos_y <= d_q[1]; pos_z <= d_q[2];
			vel_x <= d_q[3]; vel_y <= d_q[4]; vel_z <= d_q[5];
			spin_x <= d_q[15]; spin_y <= d_q[16]; spin_z <= d_q[17];
		end
	end
endmodule
`default_nettype wire

// ===== sv/gpc_mac.sv =====
`default_nettype none
module gpc_mac import gpc_pkg::*; (
	input  wire logic               clk,
	input  wire logic signed [31:0] a,
	input  wire logic        [31:0] c,
	input  wire logic        [4:0]  shift,
	output logic signed [47:0]      prod_s1
);
	logic signed [64:0] p;
	logic signed [64:0] r;
	always_comb begin
		p = a * $signed({1'b0, c});
		r = (p + (65'sd1 <<< (shift - 5'd1))) >>> shift;
	end
	// clamp leaves headroom for one more 32-bit addend
	always_ff @(posedge clk) begin
		if (r > 65'sh3fffffffffff) prod_s1 <= 48'sh3fffffffffff;
		else if (r < -65'sh400000000000) prod_s1 <= -48'sh400000000000;
		else prod_s1 <= r[47:0];
	end
endmodule
`default_nettype wire

// ===== sv/gpc_checker.sv =====
`default_nettype none
module gpc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("not busy after start");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done longer than one cycle");
endmodule
bind gear_predictor_corrector gpc_checker u_chk (.clk(clk), .arst_n(arst_n),
	.start(start), .busy(busy), .done(done));
`default_nettype wire

// ===== bench/gear_predictor_corrector_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module gear_predictor_corrector_tb;
	import gpc_pkg::*;

	typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN} kind_t;

	typedef struct {
		kind_t                 kind;
		action_t               act;
		logic [5:0]            prt;
		logic [2:0]            slt;
		logic signed [31:0]    vec[3];
		logic signed [31:0]    tq[3];
		logic signed [31:0]    gr[3];
		reg_idx_t              idx;
		logic [31:0]           data;
		int                    idle;
	} entry_t;

	typedef struct {
		logic [5:0]            prt;
		logic signed [31:0]    pos[3];
		logic signed [31:0]    vel[3];
		logic signed [31:0]    spin[3];
	} motion_t;

	localparam int SETTLE_CYC = 150;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start, busy, cfg_valid, cfg_ready, done;
	logic [1:0] action;
	logic [5:0] particle, which_particle;
	logic [2:0] slot, cfg_index;
	logic [31:0] cfg_data;
	logic signed [31:0] vec_x, vec_y, vec_z, torque_x, torque_y, torque_z;
	logic signed [31:0] gravity_x, gravity_y, gravity_z;
	logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, spin_x, spin_y, spin_z;

	gear_predictor_corrector dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .particle(particle), .slot(slot),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.torque_x(torque_x), .torque_y(torque_y), .torque_z(torque_z),
		.gravity_x(gravity_x), .gravity_y(gravity_y), .gravity_z(gravity_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .which_particle(which_particle),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
		.spin_x(spin_x), .spin_y(spin_y), .spin_z(spin_z)
	);

	always #5 clk = ~clk;

	entry_t pending[$];
	motion_t motion_q[$];
	logic signed [31:0] store[2][PARTICLES*12];
	logic [31:0] coef[NREG];
	entry_t cur;
	int settle, errors, n_items, n_cfg, n_results, idle_cnt;

	function automatic longint mulr(longint a, logic [31:0] c, int s);
		longint p;
		p = a * longint'({32'd0, c});
		return (p + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] clip(longint x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	function automatic void taylor_step(int r, int base);
		longint d0, d1, d2, d3;
		for (int a = 0; a < 3; a++) begin
			d0 = store[r][base+a];
			d1 = store[r][base+3+a];
			d2 = store[r][base+6+a];
			d3 = store[r][base+9+a];
			store[r][base+a] = clip(d0 + mulr(d1, coef[REG_STEP], COEF_FRAC)
				+ mulr(d2, coef[REG_HSQ], COEF_FRAC) + mulr(d3, coef[REG_SCUBE], COEF_FRAC));
			store[r][base+3+a] = clip(d1 + mulr(d2, coef[REG_STEP], COEF_FRAC)
				+ mulr(d3, coef[REG_HSQ], COEF_FRAC));
			store[r][base+6+a] = clip(d2 + mulr(d3, coef[REG_STEP], COEF_FRAC));
		end
	endfunction

	function automatic void gear_correct(int r, int idx, logic signed [31:0] acc);
		longint corr;
		corr = clip(longint'(acc) - longint'(store[r][idx+6]));
		store[r][idx] = clip(longint'(store[r][idx]) + mulr(corr, coef[REG_CPOS], COEF_FRAC));
		store[r][idx+3] = clip(longint'(store[r][idx+3]) + mulr(corr, coef[REG_CVEL], COEF_FRAC));
		store[r][idx+6] = acc;
		store[r][idx+9] = clip(longint'(store[r][idx+9]) + mulr(corr, coef[REG_CJERK], JERK_FRAC));
	endfunction

	function automatic void integrate(entry_t e);
		int base;
		motion_t m;
		base = int'(e.prt) * 12;
		case (e.act)
			ACT_PREDICT: begin
				taylor_step(0, base);
				taylor_step(1, base);
			end
			ACT_CORRECT: begin
				for (int a = 0; a < 3; a++) begin
					gear_correct(0, base + a, clip(mulr(e.vec[a], coef[REG_IMASS], FRAC_BITS)
						+ longint'(e.gr[a])));
					gear_correct(1, base + a, clip(mulr(e.tq[a], coef[REG_IINER], FRAC_BITS)));
				end
			end
			ACT_LOAD: begin
				for (int a = 0; a < 3; a++)
					store[e.slt[2]][base + int'(e.slt[1:0]) * 3 + a] = e.vec[a];
			end
			default: ;
		endcase
		m.prt = e.prt;
		for (int a = 0; a < 3; a++) begin
			m.pos[a] = store[0][base+a];
			m.vel[a] = store[0][base+3+a];
			m.spin[a] = store[1][base+3+a];
		end
		motion_q.push_back(m);
	endfunction

	// driver
	always @(posedge clk) begin
		logic nstart, ncfg;
		bit free;
		if (arst_n) begin
			nstart = start;
			ncfg = cfg_valid;
			free = 1;
			if (start && !busy) begin
				integrate(cur);
				n_items++;
				nstart = 0;
			end else if (start)
				free = 0;
			if (cfg_valid && cfg_ready) begin
				coef[cur.idx] = cur.data;
				n_cfg++;
				ncfg = 0;
			end else if (cfg_valid)
				free = 0;
			if (free && pending.size() > 0) begin
				case (pending[0].kind)
					K_DRAIN: begin
						if (motion_q.size() == 0 && !busy && !done) begin
							if (settle < SETTLE_CYC)
								settle++;
							else begin
								settle = 0;
								void'(pending.pop_front());
							end
						end
					end
					K_CFG: begin
						cur = pending.pop_front();
						ncfg = 1;
						cfg_index <= cur.idx;
						cfg_data <= cur.data;
					end
					default: begin
						if ($urandom_range(0, 99) >= pending[0].idle) begin
							cur = pending.pop_front();
							nstart = 1;
							action <= cur.act;
							particle <= cur.prt;
							slot <= cur.slt;
							{vec_x, vec_y, vec_z} <= {cur.vec[0], cur.vec[1], cur.vec[2]};
							{torque_x, torque_y, torque_z} <= {cur.tq[0], cur.tq[1], cur.tq[2]};
							{gravity_x, gravity_y, gravity_z} <= {cur.gr[0], cur.gr[1], cur.gr[2]};
						end
					end
				endcase
			end
			start <= nstart;
			cfg_valid <= ncfg;
		end
	end

	task automatic chk(string nm, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$error("%s expected %h got %h", nm, e, a);
			errors++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		motion_t m;
		if (arst_n && done) begin
			n_results++;
			if (motion_q.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				m = motion_q.pop_front();
				chk("which_particle", 32'(m.prt), 32'(which_particle));
				chk("pos_x", m.pos[0], pos_x);
				chk("pos_y", m.pos[1], pos_y);
				chk("pos_z", m.pos[2], pos_z);
				chk("vel_x", m.vel[0], vel_x);
				chk("vel_y", m.vel[1], vel_y);
				chk("vel_z", m.vel[2], vel_z);
				chk("spin_x", m.spin[0], spin_x);
				chk("spin_y", m.spin[1], spin_y);
				chk("spin_z", m.spin[2], spin_z);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready) || done)
			idle_cnt <= 0;
		else if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", idle_cnt);
			$display("*** FAILED ***");
			$finish;
		end else
			idle_cnt <= idle_cnt + 1;
	end

	function automatic logic signed [31:0] rand_val();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
			2: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
		endcase
	endfunction

	function automatic entry_t item(action_t act, int p, int s, logic signed [31:0] v,
			logic signed [31:0] t, logic signed [31:0] g, int idle);
		entry_t e;
		e.kind = K_ITEM;
		e.act = act;
		e.prt = 6'(p);
		e.slt = 3'(s);
		e.idle = idle;
		e.idx = REG_STEP;
		e.data = 0;
		for (int a = 0; a < 3; a++) begin
			e.vec[a] = v;
			e.tq[a] = t;
			e.gr[a] = g;
		end
		return e;
	endfunction

	task automatic add_rand(int n, int idle);
		entry_t e;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			e = item(r < 35 ? ACT_LOAD : r < 65 ? ACT_PREDICT : r < 95 ? ACT_CORRECT : ACT_NONE,
				$urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 63),
				$urandom_range(0, 7), 0, 0, 0, idle);
			for (int a = 0; a < 3; a++) begin
				e.vec[a] = rand_val();
				e.tq[a] = rand_val();
				e.gr[a] = rand_val();
			end
			pending.push_back(e);
		end
	endtask

	task automatic add_cfg(reg_idx_t idx, logic [31:0] data);
		entry_t e;
		e = item(ACT_NONE, 0, 0, 0, 0, 0, 0);
		e.kind = K_CFG;
		e.idx = idx;
		e.data = data;
		pending.push_back(e);
	endtask

	task automatic set_coefs(logic [31:0] c0, c1, c2, c3, c4, c5, c6, c7);
		entry_t e;
		e = item(ACT_NONE, 0, 0, 0, 0, 0, 0);
		e.kind = K_DRAIN;
		pending.push_back(e);
		add_cfg(REG_STEP, c0);
		add_cfg(REG_HSQ, c1);
		add_cfg(REG_SCUBE, c2);
		add_cfg(REG_CPOS, c3);
		add_cfg(REG_CVEL, c4);
		add_cfg(REG_CJERK, c5);
		add_cfg(REG_IMASS, c6);
		add_cfg(REG_IINER, c7);
	endtask

	task automatic drain_hold();
		entry_t e;
		e = item(ACT_NONE, 0, 0, 0, 0, 0, 0);
		e.kind = K_DRAIN;
		pending.push_back(e);
	endtask

	initial begin
		start = 0;
		cfg_valid = 0;
		action = ACT_PREDICT;
		particle = 0;
		slot = 0;
		cfg_index = REG_STEP;
		cfg_data = 0;
		{vec_x, vec_y, vec_z, torque_x, torque_y, torque_z} = '0;
		{gravity_x, gravity_y, gravity_z} = '0;
		errors = 0;
		n_items = 0;
		n_cfg = 0;
		n_results = 0;
		settle = 0;
		idle_cnt = 0;
		for (int r = 0; r < 2; r++)
			for (int i = 0; i < PARTICLES * 12; i++)
				store[r][i] = 0;
		for (int i = 0; i < NREG; i++)
			coef[i] = 0;

		// directed: zero coefficients first, then a modest time step
		pending.push_back(item(ACT_LOAD, 0, 1, 32'sh7fffffff, 0, 0, 10));
		pending.push_back(item(ACT_PREDICT, 0, 0, 0, 0, 0, 10));
		set_coefs(32'd65536, 32'd128, 32'd1, 32'd21, 32'd27307, 32'd65536,
			32'd65536, 32'd131072);
		for (int s = 0; s < 8; s++)
			pending.push_back(item(ACT_LOAD, 0, s, s[0] ? 32'sh7fffffff : 32'sh80000000,
				0, 0, 10));
		pending.push_back(item(ACT_PREDICT, 0, 0, 0, 0, 0, 10));
		pending.push_back(item(ACT_CORRECT, 0, 0, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 10));
		pending.push_back(item(ACT_CORRECT, 0, 0, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 10));
		pending.push_back(item(ACT_NONE, 0, 5, 32'sh1234, 32'sh1, 32'sh2, 10));
		pending.push_back(item(ACT_LOAD, 63, 3, 32'sh00010000, 0, 0, 10));
		pending.push_back(item(ACT_LOAD, 63, 5, -32'sh00020000, 0, 0, 10));
		pending.push_back(item(ACT_PREDICT, 63, 7, 0, 0, 0, 10));
		pending.push_back(item(ACT_PREDICT, 63, 0, 0, 0, 0, 10));
		pending.push_back(item(ACT_CORRECT, 63, 0, 32'sh00030000, -32'sh00010000,
			-32'sh0009cccd, 10));
		pending.push_back(item(ACT_CORRECT, 1, 0, 0, 0, 0, 10));

		set_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom);
		add_rand(100, 10);
		drain_hold();
		add_rand(100, 10);
		set_coefs('1, '1, '1, '1, '1, '1, '1, '1);
		add_rand(150, 46);
		set_coefs('0, '0, '0, '0, '0, '0, '0, '0);
		add_rand(100, 46);
		set_coefs(32'h01000000, 32'h00800000, 32'd2796203, 32'd1398101, 32'd6990507,
			32'd256, 32'h00008000, 32'h00030000);
		add_rand(200, 0);
		set_coefs($urandom_range(0, 32'h00ffffff), $urandom_range(0, 32'h000fffff),
			$urandom_range(0, 32'h0000ffff), $urandom_range(0, 32'h0000ffff),
			$urandom_range(0, 32'h00ffffff), $urandom, $urandom_range(0, 32'h00ffffff),
			$urandom_range(0, 32'h00ffffff));
		add_rand(180, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (pending.size() > 0 || start || cfg_valid || motion_q.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (motion_q.size() > 0) begin
			$error("%0d results never arrived", motion_q.size());
			errors++;
		end
		$display("ran %0d predict/correct/load beats and %0d register writes", n_items, n_cfg);
		$display("checked %0d result beats over six coefficient sets", n_results);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
